>>> src/cmp_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cmp_pkg
// Shared types and codes for the CoAP message parser: parse phases, byte
// section codes, status codes, option nibble constants and the result record.
// ----------------------------------------------------------------------------
package cmp_pkg;

   // parse phase of the current message
   typedef enum logic [2:0] {
      PH_HDR   = 3'd0,
      PH_TOK   = 3'd1,
      PH_OHEAD = 3'd2,
      PH_DEXT  = 3'd3,
      PH_LEXT  = 3'd4,
      PH_VAL   = 3'd5,
      PH_PAY   = 3'd6,
      PH_IGN   = 3'd7
   } phase_type;

   // byte classification
   localparam logic [2:0] SEC_HEADER  = 3'd0;
   localparam logic [2:0] SEC_TOKEN   = 3'd1;
   localparam logic [2:0] SEC_OPTHEAD = 3'd2;
   localparam logic [2:0] SEC_OPTVAL  = 3'd3;
   localparam logic [2:0] SEC_MARKER  = 3'd4;
   localparam logic [2:0] SEC_PAYLOAD = 3'd5;
   localparam logic [2:0] SEC_IGNORED = 3'd6;

   // message status, reported on the last byte
   localparam logic [2:0] ST_OK        = 3'd0;
   localparam logic [2:0] ST_HDR_SHORT = 3'd1;
   localparam logic [2:0] ST_VERSION   = 3'd2;
   localparam logic [2:0] ST_TOKEN     = 3'd3;
   localparam logic [2:0] ST_OPT_SHORT = 3'd4;
   localparam logic [2:0] ST_DELTA15   = 3'd5;
   localparam logic [2:0] ST_LEN15     = 3'd6;
   localparam logic [2:0] ST_OVERRUN   = 3'd7;

   // protocol constants
   localparam logic [1:0]  COAP_VERSION   = 2'd1;
   localparam logic [3:0]  TOKEN_MAX      = 4'd8;
   localparam logic [7:0]  PAYLOAD_MARKER = 8'hFF;
   localparam logic [3:0]  NIB_EXT8       = 4'd13;
   localparam logic [3:0]  NIB_EXT16      = 4'd14;
   localparam logic [3:0]  NIB_RESERVED   = 4'd15;
   localparam logic [15:0] EXT8_BIAS      = 16'd13;
   localparam logic [15:0] EXT16_BIAS     = 16'd269;
   localparam logic [7:0]  OPTION_LIMIT_RESET = 8'd16;

   // one result transaction
   typedef struct packed {
      logic [2:0]  section;
      logic [7:0]  byte_out;
      logic [15:0] option_number;
      logic [15:0] option_length;
      logic        option_ready;
      logic [7:0]  option_count;
      logic [1:0]  msg_type;
      logic [3:0]  token_length;
      logic [7:0]  code_field;
      logic [15:0] message_id;
      logic [2:0]  status;
      logic        done_res;
   } rsp_type;

endpackage

>>> src/coap_message_parser_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// coap_message_parser_core
// Streaming CoAP message parser: classifies each message byte and reports
// header fields, option number and length, and a status on the last byte.
// ----------------------------------------------------------------------------
// Usage
//   req_*  : one message byte per transaction (req_data_byte, req_last_byte),
//            taken at a clock edge with req_valid high and req_stall low.
//   rsp_*  : one result per byte, taken with rsp_valid high and rsp_stall low.
//   csr_*  : write of option_limit; csr_ready is always high. Write only while
//            no byte is in flight.
//   An accepted byte lands in an input register; one pass of parse logic
//   then updates the message state and loads the result register, which
//   drives rsp_valid. Throughput is one byte per cycle while rsp_stall is
//   low, set by that single parse pass per byte.
//   When the receiver stalls, the result register holds and the input
//   register still takes one more byte; req_stall rises only when both are
//   full and rsp_stall is high.
//   Synchronous reset empties both registers, clears the message state and
//   sets option_limit to 16. After the last byte of each message the state
//   returns to its reset values, except option_limit.
// ----------------------------------------------------------------------------
module coap_message_parser_core (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [7:0]  req_data_byte,
   input  logic        req_last_byte,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [2:0]  rsp_section,
   output logic [7:0]  rsp_byte_out,
   output logic [15:0] rsp_option_number,
   output logic [15:0] rsp_option_length,
   output logic        rsp_option_ready,
   output logic [7:0]  rsp_option_count,
   output logic [1:0]  rsp_msg_type,
   output logic [3:0]  rsp_token_length,
   output logic [7:0]  rsp_code_field,
   output logic [15:0] rsp_message_id,
   output logic [2:0]  rsp_status,
   output logic        rsp_done_res,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [7:0]  csr_data
);

   // pipeline registers
   logic              in_valid_ff;
   logic [7:0]        in_byte_ff;
   logic              in_last_ff;
   logic              rsp_valid_ff;
   cmp_pkg::rsp_type  rsp_ff;
   cmp_pkg::rsp_type  rsp_in;

   // configuration
   logic [7:0]        option_limit_ff;

   // message state
   cmp_pkg::phase_type phase_ff, phase_in;
   logic [3:0]        position_ff, position_in;
   logic [31:0]       header_ff, header_in;
   logic [15:0]       run_delta_ff, run_delta_in;
   logic [15:0]       pend_delta_ff, pend_delta_in;
   logic [15:0]       pend_len_ff, pend_len_in;
   logic [7:0]        ext_hold_ff, ext_hold_in;
   logic [15:0]       value_left_ff, value_left_in;
   logic [7:0]        opt_seen_ff, opt_seen_in;
   logic [2:0]        err_ff, err_in;

   // handshake
   logic advance;
   logic req_accept;
   logic step;

   assign advance    = !rsp_valid_ff || !rsp_stall;
   assign req_stall  = in_valid_ff && !advance;
   assign req_accept = req_valid && !req_stall;
   assign step       = in_valid_ff && advance;
   assign csr_ready  = 1'b1;

   // parse one byte
   always_comb begin
      logic [3:0]  tkl;
      logic [3:0]  d_nib;
      logic [3:0]  l_nib;
      logic [3:0]  len_nib;
      logic        do_len;
      logic        do_finish;
      logic        ready;
      logic        hdr_short;
      logic [2:0]  section;
      logic [2:0]  status;

      phase_in      = phase_ff;
      position_in   = position_ff;
      header_in     = header_ff;
      run_delta_in  = run_delta_ff;
      pend_delta_in = pend_delta_ff;
      pend_len_in   = pend_len_ff;
      ext_hold_in   = ext_hold_ff;
      value_left_in = value_left_ff;
      opt_seen_in   = opt_seen_ff;
      err_in        = err_ff;
      tkl           = header_ff[27:24];
      d_nib         = in_byte_ff[7:4];
      l_nib         = in_byte_ff[3:0];
      len_nib       = 4'd0;
      do_len        = 1'b0;
      do_finish     = 1'b0;
      ready         = 1'b0;
      hdr_short     = 1'b0;
      section       = cmp_pkg::SEC_IGNORED;
      status        = cmp_pkg::ST_OK;

      unique case (phase_ff)
         cmp_pkg::PH_HDR: begin
            section = cmp_pkg::SEC_HEADER;
            unique case (position_ff[1:0])
               2'd0: header_in[31:24] = header_ff[31:24] | in_byte_ff;
               2'd1: header_in[23:16] = header_ff[23:16] | in_byte_ff;
               2'd2: header_in[15:8]  = header_ff[15:8]  | in_byte_ff;
               default: header_in[7:0] = header_ff[7:0] | in_byte_ff;
            endcase
            if (position_ff == 4'd0 && in_byte_ff[7:6] != cmp_pkg::COAP_VERSION) begin
               err_in = cmp_pkg::ST_VERSION;
            end
            if (position_ff < 4'd3) begin
               position_in = position_ff + 4'd1;
               hdr_short   = 1'b1;
            end else begin
               position_in = 4'd0;
               if (err_in != cmp_pkg::ST_OK) begin
                  phase_in = cmp_pkg::PH_IGN;
               end else if (tkl > cmp_pkg::TOKEN_MAX) begin
                  err_in   = cmp_pkg::ST_TOKEN;
                  phase_in = cmp_pkg::PH_IGN;
               end else if (tkl == 4'd0) begin
                  phase_in = cmp_pkg::PH_OHEAD;
               end else begin
                  phase_in = cmp_pkg::PH_TOK;
               end
            end
         end
         cmp_pkg::PH_TOK: begin
            section     = cmp_pkg::SEC_TOKEN;
            position_in = position_ff + 4'd1;
            if (position_in >= tkl) begin
               position_in = 4'd0;
               phase_in    = cmp_pkg::PH_OHEAD;
            end
         end
         cmp_pkg::PH_OHEAD: begin
            if (in_byte_ff == cmp_pkg::PAYLOAD_MARKER) begin
               section  = cmp_pkg::SEC_MARKER;
               phase_in = cmp_pkg::PH_PAY;
            end else if (opt_seen_ff >= option_limit_ff) begin
               section  = cmp_pkg::SEC_IGNORED;
               phase_in = cmp_pkg::PH_IGN;
            end else begin
               section = cmp_pkg::SEC_OPTHEAD;
               if (d_nib == cmp_pkg::NIB_RESERVED) begin
                  if (err_in == cmp_pkg::ST_OK) err_in = cmp_pkg::ST_DELTA15;
                  phase_in = cmp_pkg::PH_IGN;
               end else if (d_nib == cmp_pkg::NIB_EXT8 || d_nib == cmp_pkg::NIB_EXT16) begin
                  pend_delta_in = {12'd0, d_nib};
                  pend_len_in   = {12'd0, l_nib};
                  position_in   = 4'd0;
                  phase_in      = cmp_pkg::PH_DEXT;
               end else begin
                  pend_delta_in = {12'd0, d_nib};
                  len_nib       = l_nib;
                  do_len        = 1'b1;
               end
            end
         end
         cmp_pkg::PH_DEXT: begin
            section = cmp_pkg::SEC_OPTHEAD;
            if (pend_delta_ff == {12'd0, cmp_pkg::NIB_EXT8}) begin
               pend_delta_in = {8'd0, in_byte_ff} + cmp_pkg::EXT8_BIAS;
               len_nib       = pend_len_ff[3:0];
               do_len        = 1'b1;
            end else if (position_ff == 4'd0) begin
               ext_hold_in = in_byte_ff;
               position_in = 4'd1;
            end else begin
               pend_delta_in = {ext_hold_ff, in_byte_ff} + cmp_pkg::EXT16_BIAS;
               len_nib       = pend_len_ff[3:0];
               do_len        = 1'b1;
            end
         end
         cmp_pkg::PH_LEXT: begin
            section = cmp_pkg::SEC_OPTHEAD;
            if (pend_len_ff == {12'd0, cmp_pkg::NIB_EXT8}) begin
               pend_len_in = {8'd0, in_byte_ff} + cmp_pkg::EXT8_BIAS;
               do_finish   = 1'b1;
            end else if (position_ff == 4'd0) begin
               ext_hold_in = in_byte_ff;
               position_in = 4'd1;
            end else begin
               pend_len_in = {ext_hold_ff, in_byte_ff} + cmp_pkg::EXT16_BIAS;
               do_finish   = 1'b1;
            end
         end
         cmp_pkg::PH_VAL: begin
            section       = cmp_pkg::SEC_OPTVAL;
            value_left_in = value_left_ff - 16'd1;
            if (value_left_in == 16'd0) phase_in = cmp_pkg::PH_OHEAD;
         end
         cmp_pkg::PH_PAY: begin
            section = cmp_pkg::SEC_PAYLOAD;
         end
         default: begin
            section = cmp_pkg::SEC_IGNORED;
         end
      endcase

      // take the length nibble of an option head
      if (do_len) begin
         if (len_nib == cmp_pkg::NIB_RESERVED) begin
            if (err_in == cmp_pkg::ST_OK) err_in = cmp_pkg::ST_LEN15;
            phase_in = cmp_pkg::PH_IGN;
         end else if (len_nib == cmp_pkg::NIB_EXT8 || len_nib == cmp_pkg::NIB_EXT16) begin
            pend_len_in = {12'd0, len_nib};
            position_in = 4'd0;
            phase_in    = cmp_pkg::PH_LEXT;
         end else begin
            pend_len_in = {12'd0, len_nib};
            do_finish   = 1'b1;
         end
      end

      // complete the option head
      if (do_finish) begin
         ready        = 1'b1;
         run_delta_in = run_delta_ff + pend_delta_in;
         opt_seen_in  = opt_seen_ff + 8'd1;
         if (pend_len_in == 16'd0) begin
            phase_in = cmp_pkg::PH_OHEAD;
         end else begin
            value_left_in = pend_len_in;
            phase_in      = cmp_pkg::PH_VAL;
         end
      end

      // status on the last byte, first match wins
      if (in_last_ff) begin
         priority if (hdr_short) begin
            status = cmp_pkg::ST_HDR_SHORT;
         end else if (err_in != cmp_pkg::ST_OK) begin
            status = err_in;
         end else if (phase_in == cmp_pkg::PH_TOK) begin
            status = cmp_pkg::ST_TOKEN;
         end else if (phase_in == cmp_pkg::PH_DEXT || phase_in == cmp_pkg::PH_LEXT) begin
            status = cmp_pkg::ST_OPT_SHORT;
         end else if (phase_in == cmp_pkg::PH_VAL && value_left_in != 16'd0) begin
            status = cmp_pkg::ST_OVERRUN;
         end else begin
            status = cmp_pkg::ST_OK;
         end
      end

      rsp_in.section       = section;
      rsp_in.byte_out      = in_byte_ff;
      rsp_in.option_number = run_delta_in;
      rsp_in.option_length = pend_len_in;
      rsp_in.option_ready  = ready;
      rsp_in.option_count  = opt_seen_in;
      rsp_in.msg_type      = header_in[29:28];
      rsp_in.token_length  = header_in[27:24];
      rsp_in.code_field    = header_in[23:16];
      rsp_in.message_id    = header_in[15:0];
      rsp_in.status        = status;
      rsp_in.done_res      = in_last_ff;
   end

   // input register: take a transaction whenever not stalled
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_accept) begin
         in_valid_ff <= 1'b1;
      end else if (advance) begin
         in_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (req_accept) begin
         in_byte_ff <= req_data_byte;
         in_last_ff <= req_last_byte;
      end
   end

   // result register: load when empty or being taken
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (advance) begin
         rsp_valid_ff <= in_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (step) rsp_ff <= rsp_in;
   end

   // option limit register
   always_ff @(posedge clock) begin
      if (reset) begin
         option_limit_ff <= cmp_pkg::OPTION_LIMIT_RESET;
      end else if (csr_valid && csr_ready) begin
         option_limit_ff <= csr_data;
      end
   end

   // message state: advance per byte, clear after the last byte
   always_ff @(posedge clock) begin
      if (reset || (step && in_last_ff)) begin
         phase_ff      <= cmp_pkg::PH_HDR;
         position_ff   <= 4'd0;
         header_ff     <= 32'd0;
         run_delta_ff  <= 16'd0;
         pend_delta_ff <= 16'd0;
         pend_len_ff   <= 16'd0;
         ext_hold_ff   <= 8'd0;
         value_left_ff <= 16'd0;
         opt_seen_ff   <= 8'd0;
         err_ff        <= cmp_pkg::ST_OK;
      end else if (step) begin
         phase_ff      <= phase_in;
         position_ff   <= position_in;
         header_ff     <= header_in;
         run_delta_ff  <= run_delta_in;
         pend_delta_ff <= pend_delta_in;
         pend_len_ff   <= pend_len_in;
         ext_hold_ff   <= ext_hold_in;
         value_left_ff <= value_left_in;
         opt_seen_ff   <= opt_seen_in;
         err_ff        <= err_in;
      end
   end

   // drive result ports
   assign rsp_valid         = rsp_valid_ff;
   assign rsp_section       = rsp_ff.section;
   assign rsp_byte_out      = rsp_ff.byte_out;
   assign rsp_option_number = rsp_ff.option_number;
   assign rsp_option_length = rsp_ff.option_length;
   assign rsp_option_ready  = rsp_ff.option_ready;
   assign rsp_option_count  = rsp_ff.option_count;
   assign rsp_msg_type      = rsp_ff.msg_type;
   assign rsp_token_length  = rsp_ff.token_length;
   assign rsp_code_field    = rsp_ff.code_field;
   assign rsp_message_id    = rsp_ff.message_id;
   assign rsp_status        = rsp_ff.status;
   assign rsp_done_res      = rsp_ff.done_res;

   // checks
   a_stall_only_when_full: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> (rsp_valid_ff && rsp_stall && in_valid_ff))
      else $error("input stalled while a register is free");

   a_status_on_last_only: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !rsp_ff.done_res) |-> (rsp_ff.status == cmp_pkg::ST_OK))
      else $error("status reported before the last byte");

   a_ready_is_head: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_ff.option_ready) |-> (rsp_ff.section == cmp_pkg::SEC_OPTHEAD))
      else $error("option ready outside an option head byte");

   a_clear_after_last: assert property (@(posedge clock) disable iff (reset)
      (step && in_last_ff) |=> (phase_ff == cmp_pkg::PH_HDR && position_ff == 4'd0
                                && err_ff == cmp_pkg::ST_OK && opt_seen_ff == 8'd0))
      else $error("message state not cleared after the last byte");

endmodule
